### src/asa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asa_pkg
// Shared types, constants and codes of the aligned stack allocator.
// ----------------------------------------------------------------------------
package asa_pkg;

  localparam int STACK_DEPTH  = 64;
  localparam int HEADER_BYTES = 8;

  localparam int ADDR_W   = 32;
  localparam int ADJ_W    = 8;
  localparam int ALIGN_W  = 8;
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int SHIFT_W  = $clog2(ALIGN_W);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_ZERO_SIZE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_TOP   = 3'd4
  } status_e;

  // One stack entry: adjustment below the grant and the granted address.
  typedef struct packed {
    logic [ADJ_W-1:0]  adj;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  // Shift control broadcast along the cell row.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage : asa_pkg
`default_nettype wire

### src/aligned_stack_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aligned_stack_allocator
// Last-in-first-out region allocator with aligned, header-padded grants.
// ----------------------------------------------------------------------------
// Usage:
//   Configure base_address (index 0) and region_size (index 1) through the
//   write port while idle; writing the base empties the allocator.
//   A request is taken at a rising edge with start high and busy low.
//   func 0 allocates request_size bytes at the given alignment; func 1
//   frees free_address, which must be the most recent live grant.
//   The result is registered: it appears in the cycle after the request,
//   on the result ports for exactly one cycle with done high.
//   Throughput: one request per cycle; busy stays low. The stack top is
//   always the first cell of a row of slots that shifts on push and pop,
//   so no memory read stands in the request path; the add and compare of
//   the space check sets the cycle.
//   The receiver cannot stall: a result must be taken in its done cycle.
//   Reset: position goes to base 0, used bytes and count to zero, no
//   result pending. Stack slots are not cleared; only live ones are read.
// ----------------------------------------------------------------------------
module aligned_stack_allocator import asa_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // Configuration write port
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [ADDR_W-1:0]      cfg_data_i,
  // Request channel
  input  wire                   start,
  output logic                  busy,
  input  wire                   func_i,
  input  wire [ADDR_W-1:0]      request_size_i,
  input  wire [ALIGN_W-1:0]     alignment_i,
  input  wire [ADDR_W-1:0]      free_address_i,
  // Result channel
  output logic                  done,
  output logic [STATUS_W-1:0]   status_o,
  output logic [ADDR_W-1:0]     granted_address_o,
  output logic [ADDR_W-1:0]     used_total_o,
  output logic [CNT_W-1:0]      live_allocations_o
);

  localparam int TOTAL_W = ADDR_W + 2;

  // Allocator state
  logic [ADDR_W-1:0] region_q;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] used_q, used_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Result register
  logic              done_q;
  status_e           status_q, status_d;
  logic [ADDR_W-1:0] granted_q, granted_d;
  logic [ADDR_W-1:0] used_total_q;
  logic [CNT_W-1:0]  live_q;

  logic              accept;
  logic [ADJ_W-1:0]  adj;
  logic [ADDR_W-1:0] grant_addr;
  logic [TOTAL_W-1:0] total;
  entry_t            new_entry;
  entry_t            top;
  shift_t            shift;
  entry_t            cell_out [STACK_DEPTH];

  assign accept = start & ~busy;
  assign busy   = 1'b0;

  asa_adjust u_adjust (
    .pos_i       (pos_q),
    .alignment_i (alignment_i),
    .adj_o       (adj)
  );

  assign grant_addr = pos_q + ADDR_W'(adj);
  assign total      = TOTAL_W'(used_q) + TOTAL_W'(adj) + TOTAL_W'(request_size_i);
  assign top        = cell_out[0];

  always_comb begin
    pos_d          = pos_q;
    used_d         = used_q;
    cnt_d          = cnt_q;
    status_d       = ST_OK;
    granted_d      = '0;
    shift          = '0;
    new_entry.adj  = adj;
    new_entry.addr = grant_addr;
    if (func_i == FUNC_ALLOC) begin
      // Check order: zero size, full stack, then space.
      if (request_size_i == '0) begin
        status_d = ST_ZERO_SIZE;
      end else if (cnt_q == CNT_W'(STACK_DEPTH)) begin
        status_d = ST_FULL;
      end else if (total > TOTAL_W'(region_q)) begin
        status_d = ST_NO_SPACE;
      end else begin
        shift.push = accept;
        pos_d      = grant_addr + request_size_i;
        used_d     = total[ADDR_W-1:0];
        cnt_d      = cnt_q + CNT_W'(1);
        granted_d  = grant_addr;
      end
    end else begin
      // Pop only the top grant; restore position and used bytes.
      if (cnt_q == '0 || top.addr != free_address_i) begin
        status_d = ST_NOT_TOP;
      end else begin
        shift.pop = accept;
        used_d    = used_q - ((pos_q - free_address_i) + ADDR_W'(top.adj));
        pos_d     = free_address_i - ADDR_W'(top.adj);
        cnt_d     = cnt_q - CNT_W'(1);
      end
    end
  end

  // Row of stack cells: the first cell is the top of stack.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t up, down;
    if (i == 0) begin : g_first
      assign up = new_entry;
    end else begin : g_mid
      assign up = cell_out[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down = cell_out[i];
    end else begin : g_inner
      assign down = cell_out[i+1];
    end
    asa_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (shift),
      .up_i    (up),
      .down_i  (down),
      .entry_o (cell_out[i])
    );
  end

  // Configuration and allocator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= '0;
      pos_q    <= '0;
      used_q   <= '0;
      cnt_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BASE_ADDRESS: begin
          // Reload the base and drop every live grant.
          pos_q  <= cfg_data_i;
          used_q <= '0;
          cnt_q  <= '0;
        end
        CFG_REGION_SIZE: begin
          region_q <= cfg_data_i;
        end
        default: begin
          region_q <= region_q;
        end
      endcase
    end else if (accept) begin
      pos_q  <= pos_d;
      used_q <= used_d;
      cnt_q  <= cnt_d;
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  // Result payload; hold the post-request totals.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= status_d;
      granted_q    <= granted_d;
      used_total_q <= used_d;
      live_q       <= cnt_d;
    end
  end

  assign done               = done_q;
  assign status_o           = status_q;
  assign granted_address_o  = granted_q;
  assign used_total_o       = used_total_q;
  assign live_allocations_o = live_q;

endmodule : aligned_stack_allocator
`default_nettype wire

### src/asa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asa_cell
// One stack slot; shifts down on push and up on pop.
// ----------------------------------------------------------------------------
module asa_cell import asa_pkg::*; (
  input  wire         clk_i,
  input  wire shift_t ctl_i,
  input  wire entry_t up_i,
  input  wire entry_t down_i,
  output entry_t      entry_o
);

  entry_t entry_q;

  // Payload only: contents are meaningless until pushed.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      entry_q <= up_i;
    end else if (ctl_i.pop) begin
      entry_q <= down_i;
    end
  end

  assign entry_o = entry_q;

endmodule : asa_cell
`default_nettype wire

### src/asa_adjust.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asa_adjust
// Smallest forward adjustment that aligns a position and leaves room for
// the header below it.
// ----------------------------------------------------------------------------
module asa_adjust import asa_pkg::*; (
  input  wire [ADDR_W-1:0]  pos_i,
  input  wire [ALIGN_W-1:0] alignment_i,
  output logic [ADJ_W-1:0]  adj_o
);

  localparam int CALC_W = ALIGN_W + 2;

  logic [ALIGN_W-1:0] eff;
  logic [ALIGN_W-1:0] mask;
  logic [SHIFT_W-1:0] sh;
  logic [CALC_W-1:0]  adj0;
  logic [CALC_W-1:0]  need;
  logic [CALC_W-1:0]  steps;
  logic [CALC_W-1:0]  adj;

  always_comb begin
    // Lowest set bit of the alignment; zero means byte alignment.
    if (alignment_i == '0) begin
      eff = ALIGN_W'(1);
    end else begin
      eff = alignment_i & (~alignment_i + ALIGN_W'(1));
    end
    mask = eff - ALIGN_W'(1);
    sh   = '0;
    for (int i = 0; i < ALIGN_W; i++) begin
      if (eff[i]) begin
        sh = SHIFT_W'(i);
      end
    end
    adj0  = CALC_W'((~pos_i[ALIGN_W-1:0] + ALIGN_W'(1)) & mask);
    need  = CALC_W'(HEADER_BYTES) - adj0;
    steps = (need + CALC_W'(mask)) >> sh;
    if (adj0 < CALC_W'(HEADER_BYTES)) begin
      adj = adj0 + (steps << sh);
    end else begin
      adj = adj0;
    end
    adj_o = adj[ADJ_W-1:0];
  end

endmodule : asa_adjust
`default_nettype wire

### tb/sv/aligned_stack_allocator_test.sv
// ----------------------------------------------------------------------------
// aligned_stack_allocator_test
// Self-checking bench for the aligned stack allocator. A queue of pending
// requests feeds a falling-edge driver; a rising-edge monitor tracks every
// accepted request in a local allocator model and checks each strobed
// result against the oldest prediction. Directed corner requests come
// first, then random allocate/free traffic under changing region settings
// and sender idle rates.
// ----------------------------------------------------------------------------
module aligned_stack_allocator_test;
  import asa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // How the driver resolves the free address at the moment it issues a request
  typedef enum logic [1:0] {
    ADDR_GIVEN,        // use the address stored in the request
    ADDR_TOP,          // the current top grant (a legal free)
    ADDR_TOP_FLIPPED,  // the top grant with one bit flipped
    ADDR_BURIED        // a live grant below the top when two or more are live
  } addr_mode_e;

  typedef struct {
    logic              func;
    logic [ADDR_W-1:0] size;
    logic [ALIGN_W-1:0] align;
    logic [ADDR_W-1:0] addr;
    addr_mode_e        mode;
    logic              hold;   // wait for all results before issuing
  } alloc_req_t;

  typedef struct {
    status_e           status;
    logic [ADDR_W-1:0] granted;
    logic [ADDR_W-1:0] used;
    logic [CNT_W-1:0]  live;
  } alloc_result_t;

  // DUT connections, all inputs known from time zero
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i    = CFG_BASE_ADDRESS;
  logic [ADDR_W-1:0]    cfg_data_i     = '0;
  logic                 start          = 1'b0;
  logic                 func_i         = FUNC_ALLOC;
  logic [ADDR_W-1:0]    request_size_i = '0;
  logic [ALIGN_W-1:0]   alignment_i    = '0;
  logic [ADDR_W-1:0]    free_address_i = '0;
  logic                 busy;
  logic                 done;
  logic [STATUS_W-1:0]  status_o;
  logic [ADDR_W-1:0]    granted_address_o;
  logic [ADDR_W-1:0]    used_total_o;
  logic [CNT_W-1:0]     live_allocations_o;

  // Allocator model state
  logic [ADDR_W-1:0] region_reg;
  logic [ADDR_W-1:0] cur_pos;
  logic [ADDR_W-1:0] used_bytes;
  logic [CNT_W-1:0]  live_count;
  logic [ADJ_W-1:0]  adj_stk  [STACK_DEPTH];
  logic [ADDR_W-1:0] addr_stk [STACK_DEPTH];

  alloc_req_t    request_queue[$];
  alloc_result_t expected_grants[$];

  logic        taken = 1'b0;   // request accepted at the last rising edge
  int unsigned sender_idle_pct = 0;
  int unsigned mismatches = 0;

  aligned_stack_allocator i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .start              (start),
    .busy               (busy),
    .func_i             (func_i),
    .request_size_i     (request_size_i),
    .alignment_i        (alignment_i),
    .free_address_i     (free_address_i),
    .done               (done),
    .status_o           (status_o),
    .granted_address_o  (granted_address_o),
    .used_total_o       (used_total_o),
    .live_allocations_o (live_allocations_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Limit the run; the slowest legal run is well under a tenth of this
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model helpers
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Lowest set bit of the raw alignment; zero counts as byte alignment.
  function automatic logic [ADDR_W-1:0] align_of(input logic [ALIGN_W-1:0] raw);
    logic [ALIGN_W-1:0] low;
    low = raw & (~raw + 1'b1);
    return (raw == '0) ? 32'd1 : {{(ADDR_W-ALIGN_W){1'b0}}, low};
  endfunction

  // Smallest forward step that aligns pos and leaves room for the header.
  function automatic logic [ADDR_W-1:0] header_pad(input logic [ADDR_W-1:0] pos,
                                                   input logic [ADDR_W-1:0] align);
    logic [ADDR_W-1:0] mis;
    logic [ADDR_W-1:0] adj;
    logic [ADDR_W-1:0] need;
    mis = pos & (align - 1);
    adj = (mis != 0) ? align - mis : '0;
    if (adj < 32'(HEADER_BYTES)) begin
      need = 32'(HEADER_BYTES) - adj;
      adj  = adj + align * ((need + align - 1) / align);
    end
    return adj;
  endfunction

  // Advance the model by one accepted request and produce its result.
  task automatic grant_or_release(input logic              fn,
                                  input logic [ADDR_W-1:0] size,
                                  input logic [ALIGN_W-1:0] raw_align,
                                  input logic [ADDR_W-1:0] faddr,
                                  output alloc_result_t    res);
    logic [ADDR_W-1:0] adj;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W+1:0] total;
    res.status  = ST_OK;
    res.granted = '0;
    if (fn == FUNC_ALLOC) begin
      if (size == 0) begin
        res.status = ST_ZERO_SIZE;
      end else if (live_count >= STACK_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        adj   = header_pad(cur_pos, align_of(raw_align));
        total = {2'b0, used_bytes} + {2'b0, adj} + {2'b0, size};
        if (total > {2'b0, region_reg}) begin
          res.status = ST_NO_SPACE;
        end else begin
          addr = cur_pos + adj;
          adj_stk[live_count]  = adj[ADJ_W-1:0];
          addr_stk[live_count] = addr;
          live_count  = live_count + 1'b1;
          cur_pos     = addr + size;
          used_bytes  = total[ADDR_W-1:0];
          res.granted = addr;
        end
      end
    end else begin
      if (live_count == 0 || addr_stk[live_count - 1'b1] != faddr) begin
        res.status = ST_NOT_TOP;
      end else begin
        adj        = {{(ADDR_W-ADJ_W){1'b0}}, adj_stk[live_count - 1'b1]};
        used_bytes = used_bytes - ((cur_pos - faddr) + adj);
        cur_pos    = faddr - adj;
        live_count = live_count - 1'b1;
      end
    end
    res.used = used_bytes;
    res.live = live_count;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check results, then track requests and register writes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    alloc_result_t want;
    alloc_result_t got;
    if (!rst_ni) begin
      taken      = 1'b0;
      region_reg = '0;
      cur_pos    = '0;
      used_bytes = '0;
      live_count = '0;
    end else begin
      // Check the strobed result against the oldest prediction
      if (done === 1'b1) begin
        if (expected_grants.size() == 0) begin
          flag_mismatch("result strobed with no request outstanding");
        end else begin
          want = expected_grants.pop_front();
          if (status_o !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
          if (granted_address_o !== want.granted)
            flag_mismatch($sformatf("granted_address %h, want %h",
                                    granted_address_o, want.granted));
          if (used_total_o !== want.used)
            flag_mismatch($sformatf("used_total %h, want %h", used_total_o, want.used));
          if (live_allocations_o !== want.live)
            flag_mismatch($sformatf("live_allocations %0d, want %0d",
                                    live_allocations_o, want.live));
        end
      end
      // Predict the request taken at this edge
      taken = start && !busy;
      if (taken) begin
        grant_or_release(func_i, request_size_i, alignment_i, free_address_i, got);
        expected_grants.push_back(got);
      end
      // Mirror register writes; writing the base empties the allocator
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE_ADDRESS: begin
            cur_pos    = cfg_data_i;
            used_bytes = '0;
            live_count = '0;
          end
          CFG_REGION_SIZE: region_reg = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: issue queued requests at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    logic              go;
    alloc_req_t        nxt;
    logic [ADDR_W-1:0] fa;
    int unsigned       idx;
    // Hold a request that has not been taken yet
    if (rst_ni && !(start && !taken)) begin
      go = 1'b0;
      if (request_queue.size() != 0) begin
        if (request_queue[0].hold && expected_grants.size() != 0)
          go = 1'b0;  // drain all results first
        else
          go = ($urandom_range(0, 99) >= sender_idle_pct);
      end
      if (go) begin
        nxt = request_queue.pop_front();
        // Resolve the free address from the live stack, which is current here
        fa = nxt.addr;
        case (nxt.mode)
          ADDR_TOP:
            if (live_count != 0) fa = addr_stk[live_count - 1'b1];
          ADDR_TOP_FLIPPED:
            if (live_count != 0)
              fa = addr_stk[live_count - 1'b1] ^ (32'd1 << $urandom_range(0, 31));
          ADDR_BURIED:
            if (live_count >= 2) begin
              idx = $urandom_range(0, live_count - 2);
              fa  = addr_stk[idx];
            end else if (live_count != 0) begin
              fa = addr_stk[0] + 1;
            end
          default: ;
        endcase
        func_i         <= nxt.func;
        request_size_i <= nxt.size;
        alignment_i    <= nxt.align;
        free_address_i <= fa;
        start          <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic alloc_req_t alloc_req(input logic [ADDR_W-1:0]  size,
                                           input logic [ALIGN_W-1:0] align);
    alloc_req_t r;
    r.func  = FUNC_ALLOC;
    r.size  = size;
    r.align = align;
    r.addr  = $urandom;
    r.mode  = ADDR_GIVEN;
    r.hold  = 1'b0;
    return r;
  endfunction

  function automatic alloc_req_t free_req(input addr_mode_e m,
                                          input logic [ADDR_W-1:0] addr);
    alloc_req_t r;
    r.func  = FUNC_FREE;
    r.size  = $urandom;
    r.align = ALIGN_W'($urandom);
    r.addr  = addr;
    r.mode  = m;
    r.hold  = 1'b0;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_data_i  = $urandom;
  endtask

  // Wait until every queued request is taken and every result has come back.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    do begin
      @(posedge clk_i);
      #1;
    end while (request_queue.size() != 0 || start);
    while (expected_grants.size() != 0 && waited < 50) begin
      @(posedge clk_i);
      #1;
      waited++;
    end
    if (expected_grants.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", expected_grants.size()));
      expected_grants.delete();
    end
    // Let the last result settle before touching registers
    repeat (3) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned bias;
    int unsigned pick;
    logic [ADDR_W-1:0] size;
    logic [ALIGN_W-1:0] align;
    alloc_req_t r;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    sender_idle_pct = 21;

    // Directed corners in a small region
    write_reg(CFG_BASE_ADDRESS, 32'h0000_1000);
    write_reg(CFG_REGION_SIZE,  32'h0000_0100);
    request_queue.push_back(free_req(ADDR_GIVEN, 32'h0000_1000));  // free on empty
    request_queue.push_back(alloc_req(32'd0, 8'd8));               // zero size
    request_queue.push_back(alloc_req(32'd1, 8'd1));
    request_queue.push_back(alloc_req(32'd16, 8'd128));
    request_queue.push_back(alloc_req(32'd4, 8'd0));               // zero alignment
    request_queue.push_back(alloc_req(32'd4, 8'h0C));              // not a power of two
    request_queue.push_back(alloc_req(32'd2, 8'hFF));
    request_queue.push_back(alloc_req(32'hFFFF_FFFF, 8'd1));       // no space
    request_queue.push_back(free_req(ADDR_TOP_FLIPPED, '0));       // not the top
    request_queue.push_back(free_req(ADDR_BURIED, '0));
    repeat (4) request_queue.push_back(free_req(ADDR_TOP, '0));
    request_queue.push_back(alloc_req(32'd32, 8'd64));
    request_queue.push_back(alloc_req(32'd16, 8'd2));
    request_queue.push_back(alloc_req(32'd8, 8'd32));
    request_queue.push_back(alloc_req(32'd4, 8'd16));
    request_queue.push_back(alloc_req(32'd1, 8'd8));
    repeat (2) request_queue.push_back(free_req(ADDR_TOP, '0));
    settle();

    // Region shrunk to nothing: any allocate is refused, the stack is kept
    write_reg(CFG_REGION_SIZE, 32'd0);
    request_queue.push_back(alloc_req(32'd1, 8'd1));
    request_queue.push_back(free_req(ADDR_TOP, '0));
    settle();

    // Base near the top of the address space: the grant wraps to zero
    write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFF0);
    write_reg(CFG_REGION_SIZE,  32'hFFFF_FFFF);
    request_queue.push_back(alloc_req(32'h0000_0100, 8'd16));
    request_queue.push_back(alloc_req(32'hFFFF_FFFF, 8'd4));
    request_queue.push_back(free_req(ADDR_TOP, '0));
    settle();

    // Random traffic: three sender regimes, five register settings each
    for (int regime = 0; regime < 3; regime++) begin
      sender_idle_pct = (regime == 0) ? 21 : (regime == 1) ? 87 : 0;
      for (int blk = 0; blk < 5; blk++) begin
        // Blocks one and two keep the stack and push hard to fill it
        if (blk == 0 || (blk >= 3 && $urandom_range(0, 1) == 1)) begin
          case ($urandom_range(0, 3))
            0:       write_reg(CFG_BASE_ADDRESS, 32'h0);
            1:       write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
            2:       write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FF00 | $urandom_range(0, 255));
            default: write_reg(CFG_BASE_ADDRESS, $urandom);
          endcase
        end
        if (blk == 1 || blk == 2) begin
          bias = 92;
          write_reg(CFG_REGION_SIZE,
                    $urandom_range(0, 1) ? 32'hFFFF_FFFF : (32'h0001_0000 | $urandom));
        end else begin
          pick = $urandom_range(0, 2);
          bias = (pick == 0) ? 30 : (pick == 1) ? 55 : 75;
          case ($urandom_range(0, 4))
            0:       write_reg(CFG_REGION_SIZE, 32'd0);
            1:       write_reg(CFG_REGION_SIZE, $urandom_range(1, 1024));
            2:       write_reg(CFG_REGION_SIZE, 32'h0001_0000);
            3:       write_reg(CFG_REGION_SIZE, 32'hFFFF_FFFF);
            default: write_reg(CFG_REGION_SIZE, $urandom);
          endcase
        end

        for (int n = 0; n < 50; n++) begin
          if ($urandom_range(0, 99) < bias) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)       size = '0;
            else if (pick < 15) size = $urandom;
            else if (pick < 25) size = $urandom_range(1, 4096);
            else                size = $urandom_range(1, 64);
            if ($urandom_range(0, 99) < 85) align = 8'd1 << $urandom_range(0, 7);
            else                            align = ALIGN_W'($urandom);
            r = alloc_req(size, align);
          end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75)      r = free_req(ADDR_TOP, $urandom);
            else if (pick < 85) r = free_req(ADDR_TOP_FLIPPED, $urandom);
            else if (pick < 93) r = free_req(ADDR_BURIED, $urandom);
            else                r = free_req(ADDR_GIVEN, $urandom);
          end
          // Now and then hold the sender until the block has answered everything
          r.hold = (n == 0) || ($urandom_range(0, 99) < 3);
          request_queue.push_back(r);
        end
        settle();
      end
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule : aligned_stack_allocator_test

### filelist.f
src/asa_pkg.sv
src/asa_cell.sv
src/asa_adjust.sv
src/aligned_stack_allocator.sv
tb/sv/aligned_stack_allocator_test.sv
